// ----- src/sbag_pkg.sv -----
// shared types and constants of the scaled blit address generator
// no dependencies
`default_nettype none
package sbag_pkg;

	localparam int DIM_W         = 13;
	localparam int COORD_W       = 14;
	localparam int OFS_W         = 24;
	localparam int STEP_W        = 32;
	localparam int MAX_DIM_DEF   = 4096;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int PADDR_W       = 5;

	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_SOURCE_PITCH  = 3'd2;
	localparam logic [2:0] REG_DEST_WIDTH    = 3'd3;
	localparam logic [2:0] REG_DEST_HEIGHT   = 3'd4;
	localparam logic [2:0] REG_DEST_PITCH    = 3'd5;
	localparam logic [2:0] REG_SOURCE_DEPTH  = 3'd6;
	localparam logic [2:0] REG_DEST_DEPTH    = 3'd7;

	typedef enum logic [1:0] {
		ST_PIXEL = 2'd0,
		ST_END   = 2'd1,
		ST_IDLE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_STEP  = 2'd0,
		K_EMPTY = 2'd1,
		K_SETUP = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_CHECK,
		F_DIV,
		F_BASE_S,
		F_BASE_D,
		F_PUSH
	} fstate_t;

	typedef struct packed {
		logic [DIM_W-1:0] source_width;
		logic [DIM_W-1:0] source_height;
		logic [DIM_W-1:0] source_pitch;
		logic [DIM_W-1:0] dest_width;
		logic [DIM_W-1:0] dest_height;
		logic [DIM_W-1:0] dest_pitch;
		logic             source_depth;
		logic             dest_depth;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [STEP_W-1:0] x_step;
		logic [STEP_W-1:0] y_step;
		logic [OFS_W-1:0]  src_base;
		logic [OFS_W-1:0]  dst_base;
		logic [DIM_W-1:0]  run_w;
		logic [DIM_W-1:0]  run_h;
		logic              expand;
	} entry_t;

endpackage
`default_nettype wire

// ----- src/sbag_cmd_if.sv -----
// input channel: start and step items
// depends on sbag_pkg
`default_nettype none
interface sbag_cmd_if;
	import sbag_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic signed [COORD_W-1:0] src_x;
	logic signed [COORD_W-1:0] src_y;
	logic signed [COORD_W-1:0] src_w;
	logic signed [COORD_W-1:0] src_h;
	logic signed [COORD_W-1:0] dst_x;
	logic signed [COORD_W-1:0] dst_y;
	logic signed [COORD_W-1:0] dst_w;
	logic signed [COORD_W-1:0] dst_h;
	modport source (output valid, action, src_x, src_y, src_w, src_h,
		dst_x, dst_y, dst_w, dst_h, input ready);
	modport sink (input valid, action, src_x, src_y, src_w, src_h,
		dst_x, dst_y, dst_w, dst_h, output ready);
endinterface
`default_nettype wire

// ----- src/sbag_res_if.sv -----
// output channel: pixel address pairs and status items
// depends on sbag_pkg
`default_nettype none
interface sbag_res_if;
	import sbag_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [OFS_W-1:0] src_offset;
	logic [OFS_W-1:0] dst_offset;
	logic             expand_palette;
	logic             last;
	modport source (output valid, status, src_offset, dst_offset, expand_palette, last,
		input ready);
	modport sink (input valid, status, src_offset, dst_offset, expand_palette, last,
		output ready);
endinterface
`default_nettype wire

// ----- src/sbag_front.sv -----
// front end: accepts items, clips rectangles, divides for steps, forms row bases
// depends on sbag_pkg and sbag_cmd_if
`default_nettype none
module sbag_front #(
	parameter int MAX_DIM   = sbag_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = sbag_pkg::FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sbag_pkg::cfg_t      cfg,
	sbag_cmd_if.sink            cmd,
	output logic                push,
	output sbag_pkg::entry_t    entry,
	input  wire                 full
);
	import sbag_pkg::*;

	localparam int CNT_W = $clog2(STEP_W);

	typedef struct packed {
		logic signed [16:0] pos;
		logic signed [16:0] len;
	} clip_t;

	function automatic clip_t clip_axis(input logic signed [16:0] pos,
		input logic signed [16:0] len, input logic signed [16:0] size);
		clip_t r;
		r.pos = pos;
		r.len = len;
		if (pos < 0) begin
			r.len = len + pos;
			r.pos = '0;
		end
		if (r.pos + r.len > size)
			r.len = size - r.pos;
		return r;
	endfunction

	function automatic logic signed [16:0] dim_limit(input logic [DIM_W-1:0] r);
		if (32'(r) > MAX_DIM)
			return 17'(MAX_DIM);
		return 17'(r);
	endfunction

	fstate_t state_q, state_d;
	clip_t cx, cy, cdx, cdy;
	clip_t sx_q, sy_q, dx_q, dy_q;
	logic [STEP_W-1:0] quo_q, x_step_q, y_step_q;
	logic [DIM_W-1:0]  rem_q, divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              phase_q;
	logic [OFS_W-1:0]  src_base_q, dst_base_q;
	logic [DIM_W:0]    rem_sh;
	logic              qbit;
	logic [DIM_W-1:0]  rem_nx;
	logic [STEP_W-1:0] quo_nx;
	logic              empty_cmd;
	logic [2*DIM_W-1:0] base_s, base_d;

	always_comb begin
		cx  = clip_axis(17'(cmd.src_x), 17'(cmd.src_w), dim_limit(cfg.source_width));
		cy  = clip_axis(17'(cmd.src_y), 17'(cmd.src_h), dim_limit(cfg.source_height));
		cdx = clip_axis(17'(cmd.dst_x), 17'(cmd.dst_w), dim_limit(cfg.dest_width));
		cdy = clip_axis(17'(cmd.dst_y), 17'(cmd.dst_h), dim_limit(cfg.dest_height));
	end

	assign empty_cmd = (sx_q.len <= 0) || (sy_q.len <= 0) || (dx_q.len <= 0) ||
		(dy_q.len <= 0) || (cfg.source_depth && !cfg.dest_depth);

	assign rem_sh = {rem_q, quo_q[STEP_W-1]};
	assign qbit   = rem_sh >= {1'b0, divisor_q};
	assign rem_nx = qbit ? DIM_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[DIM_W-1:0];
	assign quo_nx = {quo_q[STEP_W-2:0], qbit};

	assign base_s = (2*DIM_W)'(sy_q.pos[DIM_W-1:0]) * (2*DIM_W)'(cfg.source_pitch) +
		(2*DIM_W)'(sx_q.pos[DIM_W-1:0]);
	assign base_d = (2*DIM_W)'(dy_q.pos[DIM_W-1:0]) * (2*DIM_W)'(cfg.dest_pitch) +
		(2*DIM_W)'(dx_q.pos[DIM_W-1:0]);

	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		cmd.ready = (state_q == F_IDLE) && !full;
		entry.kind     = K_STEP;
		entry.x_step   = x_step_q;
		entry.y_step   = y_step_q;
		entry.src_base = src_base_q;
		entry.dst_base = dst_base_q;
		entry.run_w    = dx_q.len[DIM_W-1:0];
		entry.run_h    = dy_q.len[DIM_W-1:0];
		entry.expand   = !cfg.source_depth && cfg.dest_depth;
		case (state_q)
			F_IDLE: begin
				if (cmd.valid && cmd.ready) begin
					if (cmd.action)
						push = 1'b1;
					else
						state_d = F_CHECK;
				end
			end
			F_CHECK: begin
				if (empty_cmd) begin
					if (!full) begin
						push       = 1'b1;
						entry.kind = K_EMPTY;
						state_d    = F_IDLE;
					end
				end else begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				if (cnt_q == CNT_W'(STEP_W - 1) && phase_q)
					state_d = F_BASE_S;
			end
			F_BASE_S: state_d = F_BASE_D;
			F_BASE_D: state_d = F_PUSH;
			F_PUSH: begin
				if (!full) begin
					push       = 1'b1;
					entry.kind = K_SETUP;
					state_d    = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && cmd.valid && cmd.ready && !cmd.action) begin
			sx_q <= cx;
			sy_q <= cy;
			dx_q <= cdx;
			dy_q <= cdy;
		end
		if (state_q == F_CHECK) begin
			quo_q     <= STEP_W'(sx_q.len[DIM_W-1:0]) << FRAC_BITS;
			divisor_q <= dx_q.len[DIM_W-1:0];
			rem_q     <= '0;
			cnt_q     <= '0;
			phase_q   <= 1'b0;
		end
		if (state_q == F_DIV) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEP_W - 1)) begin
				if (!phase_q) begin
					x_step_q  <= quo_nx;
					quo_q     <= STEP_W'(sy_q.len[DIM_W-1:0]) << FRAC_BITS;
					divisor_q <= dy_q.len[DIM_W-1:0];
					rem_q     <= '0;
					phase_q   <= 1'b1;
				end else begin
					y_step_q <= quo_nx;
				end
			end else begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
			end
		end
		if (state_q == F_BASE_S)
			src_base_q <= base_s[OFS_W-1:0];
		if (state_q == F_BASE_D)
			dst_base_q <= base_d[OFS_W-1:0];
	end

endmodule
`default_nettype wire

// ----- src/sbag_queue.sv -----
// short queue of classified commands between front and back
// depends on sbag_pkg
`default_nettype none
module sbag_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  sbag_pkg::entry_t wr_entry,
	input  wire              pop,
	output sbag_pkg::entry_t rd_entry,
	output logic             full,
	output logic             empty
);
	import sbag_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign rd_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(push && !full) - CNT_W'(pop && !empty);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule
`default_nettype wire

// ----- src/sbag_back.sv -----
// back end: nearest neighbor walk over the destination rectangle, output register
// depends on sbag_pkg and sbag_res_if
`default_nettype none
module sbag_back #(
	parameter int FRAC_BITS = sbag_pkg::FRAC_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  sbag_pkg::cfg_t   cfg,
	input  sbag_pkg::entry_t entry,
	input  wire              empty,
	output logic             pop,
	sbag_res_if.source       res
);
	import sbag_pkg::*;

	localparam int MUL_W = DIM_W + STEP_W;

	logic              busy_q, res_valid_q;
	logic [DIM_W-1:0]  col_q, row_q, run_w_q, run_h_q;
	logic [STEP_W-1:0] x_frac_q, x_step_q, y_step_q;
	logic [FRAC_BITS-1:0] y_frac_q;
	logic [OFS_W-1:0]  src_base_q, dst_base_q;
	logic              expand_q;
	status_t           status_q;
	logic [OFS_W-1:0]  so_q, do_q;
	logic              ex_q, last_q;

	logic [OFS_W-1:0]  so, d;
	logic [DIM_W-1:0]  col_inc, row_inc;
	logic              row_end, cmd_end;
	logic [STEP_W-1:0] adv;
	logic [MUL_W-1:0]  adv_mul;

	assign pop     = !empty && (!res_valid_q || res.ready);
	assign so      = src_base_q + OFS_W'(x_frac_q >> FRAC_BITS);
	assign d       = dst_base_q + OFS_W'(col_q);
	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;
	assign row_end = col_inc >= run_w_q;
	assign cmd_end = row_end && (row_inc >= run_h_q);
	assign adv     = STEP_W'(y_frac_q) + y_step_q;
	assign adv_mul = MUL_W'(cfg.source_pitch) * MUL_W'(adv >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && (entry.kind == K_STEP || entry.kind == K_EMPTY))
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			if (pop) begin
				case (entry.kind)
					K_STEP: begin
						if (busy_q && cmd_end)
							busy_q <= 1'b0;
					end
					K_EMPTY: busy_q <= 1'b0;
					K_SETUP: busy_q <= 1'b1;
					default: busy_q <= busy_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			case (entry.kind)
				K_STEP: begin
					if (!busy_q) begin
						status_q <= ST_IDLE;
						so_q     <= '0;
						do_q     <= '0;
						ex_q     <= 1'b0;
						last_q   <= 1'b0;
					end else begin
						status_q <= ST_PIXEL;
						so_q     <= so;
						do_q     <= d;
						ex_q     <= expand_q;
						last_q   <= cmd_end;
						if (row_end) begin
							col_q      <= '0;
							x_frac_q   <= '0;
							row_q      <= row_inc;
							dst_base_q <= dst_base_q + OFS_W'(cfg.dest_pitch);
							src_base_q <= src_base_q + adv_mul[OFS_W-1:0];
							y_frac_q   <= adv[FRAC_BITS-1:0];
						end else begin
							col_q    <= col_inc;
							x_frac_q <= x_frac_q + x_step_q;
						end
					end
				end
				K_EMPTY: begin
					status_q <= ST_END;
					so_q     <= '0;
					do_q     <= '0;
					ex_q     <= 1'b0;
					last_q   <= 1'b1;
				end
				K_SETUP: begin
					x_step_q   <= entry.x_step;
					y_step_q   <= entry.y_step;
					src_base_q <= entry.src_base;
					dst_base_q <= entry.dst_base;
					run_w_q    <= entry.run_w;
					run_h_q    <= entry.run_h;
					expand_q   <= entry.expand;
					col_q      <= '0;
					row_q      <= '0;
					x_frac_q   <= '0;
					y_frac_q   <= '0;
				end
				default: expand_q <= expand_q;
			endcase
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = status_q;
	assign res.src_offset     = so_q;
	assign res.dst_offset     = do_q;
	assign res.expand_palette = ex_q;
	assign res.last           = last_q;

endmodule
`default_nettype wire

// ----- src/scaled_blit_address_generator.sv -----
// top level: configuration registers, front end, command queue, back end
// depends on sbag_pkg, sbag_cmd_if, sbag_res_if, sbag_front, sbag_queue, sbag_back
//
// channel  dir  handshake      carries
// cmd      in   valid/ready    action and source/destination rectangles
// res      out  valid/ready    status, src/dst offsets, expand_palette, last
// apb      in   psel/penable   surface sizes, pitches and depths
//
// step items: one per cycle while the queue is not full and res is not stalled, each taken by the walk in the back end
// start items: the front end clips, then runs the shared divider
//   at one quotient bit per cycle for the x then the y step
// the queue lets step items of a running command drain while a new start divides
// arst_n clears all control state; no clearing pass
// res stalls fill the queue, then cmd.ready drops
`default_nettype none
module scaled_blit_address_generator #(
	parameter int MAX_DIM   = sbag_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = sbag_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [sbag_pkg::PADDR_W-1:0] paddr,
	input  wire [31:0]                  pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	sbag_cmd_if.sink                    cmd,
	sbag_res_if.source                  res
);
	import sbag_pkg::*;

	cfg_t   cfg_q;
	entry_t wr_entry, rd_entry;
	logic   push, pop, full, empty;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width  <= DIM_W'(320);
			cfg_q.source_height <= DIM_W'(200);
			cfg_q.source_pitch  <= DIM_W'(320);
			cfg_q.dest_width    <= DIM_W'(640);
			cfg_q.dest_height   <= DIM_W'(400);
			cfg_q.dest_pitch    <= DIM_W'(640);
			cfg_q.source_depth  <= 1'b0;
			cfg_q.dest_depth    <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_SOURCE_WIDTH:  cfg_q.source_width  <= pwdata[DIM_W-1:0];
				REG_SOURCE_HEIGHT: cfg_q.source_height <= pwdata[DIM_W-1:0];
				REG_SOURCE_PITCH:  cfg_q.source_pitch  <= pwdata[DIM_W-1:0];
				REG_DEST_WIDTH:    cfg_q.dest_width    <= pwdata[DIM_W-1:0];
				REG_DEST_HEIGHT:   cfg_q.dest_height   <= pwdata[DIM_W-1:0];
				REG_DEST_PITCH:    cfg_q.dest_pitch    <= pwdata[DIM_W-1:0];
				REG_SOURCE_DEPTH:  cfg_q.source_depth  <= pwdata[0];
				REG_DEST_DEPTH:    cfg_q.dest_depth    <= pwdata[0];
				default:           cfg_q.dest_depth    <= cfg_q.dest_depth;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SOURCE_WIDTH:  prdata = 32'(cfg_q.source_width);
			REG_SOURCE_HEIGHT: prdata = 32'(cfg_q.source_height);
			REG_SOURCE_PITCH:  prdata = 32'(cfg_q.source_pitch);
			REG_DEST_WIDTH:    prdata = 32'(cfg_q.dest_width);
			REG_DEST_HEIGHT:   prdata = 32'(cfg_q.dest_height);
			REG_DEST_PITCH:    prdata = 32'(cfg_q.dest_pitch);
			REG_SOURCE_DEPTH:  prdata = 32'(cfg_q.source_depth);
			REG_DEST_DEPTH:    prdata = 32'(cfg_q.dest_depth);
			default:           prdata = '0;
		endcase
	end

	sbag_front #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.push   (push),
		.entry  (wr_entry),
		.full   (full)
	);

	sbag_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (full),
		.empty    (empty)
	);

	sbag_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.entry  (rd_entry),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule
`default_nettype wire
